@@ hdl/prewitt_edge_magnitude_macros.svh @@
// Assertion macros shared by the Prewitt edge magnitude checker.
`ifndef PREWITT_EDGE_MAGNITUDE_MACROS_SVH
`define PREWITT_EDGE_MAGNITUDE_MACROS_SVH

// Assert a property on every rising clock edge outside reset.
`define PE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that a cause is followed by an effect in the next cycle.
`define PE_ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cause) |=> (effect)) else $error(msg);

`endif

@@ hdl/pe_pkg.sv @@
// Shared types and constants of the Prewitt edge magnitude block.
package pe_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned SUM_W   = 10;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned APB_AW  = 2;
  localparam int unsigned APB_DW  = 32;

  localparam logic [CFG_W-1:0]  IMAGE_WIDTH_RST = 11'd1024;
  localparam logic [CFG_W-1:0]  IMAGE_WIDTH_MIN = 11'd3;
  localparam logic [PIX_W-1:0]  MAG_MAX         = 8'd255;
  localparam logic [APB_AW-1:0] ADDR_IMAGE_WIDTH = 2'd0;

  // One window column: top, middle and bottom pixel.
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } pix_col_t;

endpackage

@@ hdl/pe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pe_ram import pe_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold the last read while no new read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/pe_pos.sv @@
// Raster position counters and window-fit decision.
module pe_pos import pe_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  logic                          frame_start_i,
  input  logic [CFG_W-1:0]              image_width_i,
  output logic [$clog2(MAX_WIDTH)-1:0]  col_o,
  output logic [$clog2(MAX_HEIGHT)-1:0] row_o,
  output logic                          win_valid_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned EW = $clog2(MAX_WIDTH + 1);

  logic [CW-1:0] col_q, col_d, col_cur;
  logic [RW-1:0] row_q, row_d, row_cur;
  logic [EW-1:0] eff_width;
  logic          last_col, last_row;

  // clamp the programmed width into the supported range
  always_comb begin
    if (image_width_i < IMAGE_WIDTH_MIN) begin
      eff_width = EW'(IMAGE_WIDTH_MIN);
    end else if (32'(image_width_i) > 32'(MAX_WIDTH)) begin
      eff_width = EW'(MAX_WIDTH);
    end else begin
      eff_width = EW'(image_width_i);
    end
  end

  assign col_cur  = frame_start_i ? '0 : col_q;
  assign row_cur  = frame_start_i ? '0 : row_q;
  assign last_col = (32'(col_cur) + 32'd1) >= 32'(eff_width);
  assign last_row = (32'(row_cur) + 32'd1) >= 32'(MAX_HEIGHT);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (acc_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_cur + RW'(1);
      end else begin
        col_d = col_cur + CW'(1);
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o       = col_cur;
  assign row_o       = row_cur;
  assign win_valid_o = (row_cur >= RW'(2)) && (col_cur >= CW'(2));

endmodule

@@ hdl/pe_grad.sv @@
// Window column registers and Prewitt gradient magnitude.
module pe_grad import pe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  pix_col_t         cur_i,
  output logic [PIX_W-1:0] mag_o
);

  pix_col_t          left_q, centre_q;
  logic [SUM_W-1:0]  sum_left, sum_right, sum_up, sum_down;
  logic [SUM_W-1:0]  gx, gy;
  logic [SUM_W:0]    mag_full;

  assign sum_left  = SUM_W'(left_q.top) + SUM_W'(left_q.mid) + SUM_W'(left_q.bot);
  assign sum_right = SUM_W'(cur_i.top) + SUM_W'(cur_i.mid) + SUM_W'(cur_i.bot);
  assign sum_up    = SUM_W'(left_q.top) + SUM_W'(centre_q.top) + SUM_W'(cur_i.top);
  assign sum_down  = SUM_W'(left_q.bot) + SUM_W'(centre_q.bot) + SUM_W'(cur_i.bot);

  assign gx = (sum_left > sum_right) ? sum_left - sum_right : sum_right - sum_left;
  assign gy = (sum_up > sum_down) ? sum_up - sum_down : sum_down - sum_up;

  assign mag_full = (SUM_W + 1)'(gx) + (SUM_W + 1)'(gy);
  assign mag_o    = (mag_full > (SUM_W + 1)'(MAG_MAX)) ? MAG_MAX : PIX_W'(mag_full);

  // advance the window: centre becomes left, current becomes centre
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      centre_q <= '0;
    end else if (shift_i) begin
      left_q   <= centre_q;
      centre_q <= cur_i;
    end
  end

endmodule

@@ hdl/prewitt_edge_magnitude.sv @@
// Top level of the streaming 3x3 Prewitt edge magnitude block.
// Pixels enter in raster order and each one yields exactly one result
// transaction, held in the gradient stage and then the output register.
// The rate is one pixel per cycle unless the output stalls, set by the
// single read port of each line store: every pixel issues one read of
// both stores at its column on acceptance and writes both back when it
// leaves the gradient stage. A write and a read of the same
// column meeting on one edge (two frame starts in a row) are resolved by
// forwarding the written bytes. The result carries |Gx|+|Gy| saturated to
// 255 and the top-left row and column of the window; pixels whose window
// does not fit in the image give an invalid result with all fields zero.
// image_width (byte address 0) is clamped to 3..MAX_WIDTH and must only be
// written while no transaction is in flight. No clearing pass is needed:
// a valid window reads only line store entries written in the same frame.
module prewitt_edge_magnitude import pe_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // pixel input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PIX_W-1:0]    pixel_i,
  input  logic                frame_start_i,
  // result output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PIX_W-1:0]    edge_magnitude_o,
  output logic                window_valid_o,
  output logic [COORD_W-1:0]  window_row_o,
  output logic [COORD_W-1:0]  window_col_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] image_width_q, image_width_d;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_IMAGE_WIDTH);

  always_comb begin
    image_width_d = image_width_q;
    if (cfg_wr) begin
      image_width_d = pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= IMAGE_WIDTH_RST;
    end else begin
      image_width_q <= image_width_d;
    end
  end

  assign prdata = (paddr == ADDR_IMAGE_WIDTH) ? APB_DW'(image_width_q) : '0;

  // ---------------------------------------------------------------------
  // Handshake: input stage, gradient stage, output register
  // ---------------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free, s1_fire, s1_free, in_acc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign s1_free    = !s1_valid_q || s1_fire;
  assign in_stall_o = !s1_free;
  assign in_acc     = in_valid_i && s1_free;

  // ---------------------------------------------------------------------
  // Position of the incoming pixel
  // ---------------------------------------------------------------------
  logic [CW-1:0] rd_col;
  logic [RW-1:0] rd_row;
  logic          rd_win;

  pe_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (in_acc),
    .frame_start_i (frame_start_i),
    .image_width_i (image_width_q),
    .col_o         (rd_col),
    .row_o         (rd_row),
    .win_valid_o   (rd_win)
  );

  // ---------------------------------------------------------------------
  // Gradient stage registers (payload needs no reset)
  // ---------------------------------------------------------------------
  logic [PIX_W-1:0] s1_px_q;
  logic [CW-1:0]    s1_col_q;
  logic [RW-1:0]    s1_row_q;
  logic             s1_win_q;
  logic             fwd_q;
  logic [PIX_W-1:0] fwd_top_q, fwd_mid_q;
  logic [PIX_W-1:0] upper_rdata, middle_rdata;
  pix_col_t         cur_col;
  logic [PIX_W-1:0] mag;

  // take forwarded bytes when the store was written on the read edge
  assign cur_col.top = fwd_q ? fwd_top_q : upper_rdata;
  assign cur_col.mid = fwd_q ? fwd_mid_q : middle_rdata;
  assign cur_col.bot = s1_px_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_px_q   <= pixel_i;
      s1_col_q  <= rd_col;
      s1_row_q  <= rd_row;
      s1_win_q  <= rd_win;
      fwd_q     <= s1_fire && (s1_col_q == rd_col);
      fwd_top_q <= cur_col.mid;
      fwd_mid_q <= s1_px_q;
    end
  end

  // ---------------------------------------------------------------------
  // Line stores: read on acceptance, write back when the gradient stage
  // hands its transaction on (upper takes the middle byte, middle the pixel)
  // ---------------------------------------------------------------------
  pe_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (cur_col.mid),
    .re_i    (in_acc),
    .raddr_i (rd_col),
    .rdata_o (upper_rdata)
  );

  pe_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_middle_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (s1_px_q),
    .re_i    (in_acc),
    .raddr_i (rd_col),
    .rdata_o (middle_rdata)
  );

  pe_grad u_grad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_fire),
    .cur_i   (cur_col),
    .mag_o   (mag)
  );

  // ---------------------------------------------------------------------
  // Valid flags
  // ---------------------------------------------------------------------
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: hold while stalled, zero the fields of a misfit window
  // ---------------------------------------------------------------------
  logic [PIX_W-1:0]   mag_q;
  logic               win_q;
  logic [COORD_W-1:0] row_q, col_q;
  logic [RW-1:0]      row_off;
  logic [CW-1:0]      col_off;

  assign row_off = s1_row_q - RW'(2);
  assign col_off = s1_col_q - CW'(2);

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      mag_q <= s1_win_q ? mag : '0;
      win_q <= s1_win_q;
      row_q <= s1_win_q ? COORD_W'(row_off) : '0;
      col_q <= s1_win_q ? COORD_W'(col_off) : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign edge_magnitude_o = mag_q;
  assign window_valid_o   = win_q;
  assign window_row_o     = row_q;
  assign window_col_o     = col_q;

endmodule

@@ hdl/pe_check.sv @@
// Port-level checker for the Prewitt edge magnitude block, with its bind.
`include "prewitt_edge_magnitude_macros.svh"

module pe_check import pe_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [PIX_W-1:0]   edge_magnitude_o,
  input logic               window_valid_o,
  input logic [COORD_W-1:0] window_row_o,
  input logic [COORD_W-1:0] window_col_o
);

  // a misfit window carries all-zero fields
  `PE_ASSERT(a_misfit_zero, out_valid_o && !window_valid_o |-> edge_magnitude_o == '0 && window_row_o == '0 && window_col_o == '0, "misfit window with non-zero fields")

  // the input only stalls behind a held, stalled result
  `PE_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without output back-pressure")

  // an accepted pixel reaches the output once the output is not stalled
  `PE_ASSERT(a_latency, (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o, "accepted pixel gave no result")

  // a stalled result holds
  `PE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(edge_magnitude_o) && $stable(window_valid_o) && $stable(window_row_o) && $stable(window_col_o), "stalled result changed")

endmodule

bind prewitt_edge_magnitude pe_check u_pe_check (.*);
